@@ sv/sqvt_pkg.sv @@
`default_nettype none

package sqvt_pkg;

  // Angle and trigonometric precision.
  localparam int ANGLE_BITS     = 12;
  localparam int TRIG_FRAC_BITS = 14;

  // Quarter-wave sine table: entries 0 .. QUARTER inclusive.
  localparam int QUARTER     = 1 << (ANGLE_BITS - 2);
  localparam int SINE_DEPTH  = QUARTER + 1;
  localparam int SINE_ADDR_W = ANGLE_BITS - 1;
  localparam int SINE_W      = TRIG_FRAC_BITS + 1;
  localparam int TRIG_W      = TRIG_FRAC_BITS + 2;

  // Field widths.
  localparam int POS_W      = 16;
  localparam int DIM_W      = 12;
  localparam int IDX_W      = 2;
  localparam int CORNERS    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int IN_DATA_W  = ((2 * POS_W + ANGLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = 2 * POS_W;
  localparam int OUT_USER_W = IDX_W + 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 2'd2;

  localparam logic [IDX_W-1:0] LAST_CORNER = IDX_W'(CORNERS - 1);

  typedef enum logic [1:0] {
    PIVOT_CENTER    = 2'd0,
    PIVOT_TOP_LEFT  = 2'd1,
    PIVOT_TOP_RIGHT = 2'd2
  } pivot_mode_t;

  typedef logic [SINE_W-1:0] sine_tab_t [SINE_DEPTH];

  typedef struct packed {
    logic                   en;
    logic [SINE_ADDR_W-1:0] sin_addr;
    logic [SINE_ADDR_W-1:0] cos_addr;
  } sine_req_t;

  typedef struct packed {
    logic [SINE_W-1:0] sin_mag;
    logic [SINE_W-1:0] cos_mag;
  } sine_rsp_t;

  // pi/2 in Q30 and the Taylor series divisors (2n)(2n+1).
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] DIV_TAB [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  // One quarter-wave entry, evaluated at elaboration only.
  function automatic logic [SINE_W-1:0] sqvt_quarter_sine(input logic [SINE_ADDR_W-1:0] k);
    logic        [63:0] x;
    logic        [63:0] x2;
    logic        [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] rnd;
    x    = (64'(k) * PI_HALF_Q30) >> (ANGLE_BITS - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int n = 0; n < 6; n++) begin
      term = ((term * x2) >> 30) / DIV_TAB[n];
      if ((n % 2) == 0) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (64'sd1 <<< 30)) begin
      sum = 64'sd1 <<< 30;
    end
    rnd = (sum + (64'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
    return rnd[SINE_W-1:0];
  endfunction

  function automatic sine_tab_t sqvt_build_sine();
    sine_tab_t t;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      t[k] = sqvt_quarter_sine(SINE_ADDR_W'(k));
    end
    return t;
  endfunction

endpackage

`default_nettype wire

@@ sv/sprite_quad_vertex_transform.sv @@
`default_nettype none

// Channel   Direction  Handshake                 Contents
// in_*      input      in_tvalid / in_tready     one sprite: position and angle
// out_*     output     out_tvalid / out_tready   one corner per transaction, tlast on the fourth
// cfg_*     input      cfg_we                    pivot mode, width, height
//
// A sprite passes four register stages: sine ROM read, products, rounded offsets and
// saturated corners. Its first corner is offered by the stage D register after it has passed
// stages A, B and C in that order; a stall at any stage can hold it back.
// One corner moves per cycle while out_tready is high; stage D refills as its last is taken.
// rst_n is synchronous and active low; it clears the stage valid bits, the corner counter
// and the configuration registers. Back-pressure travels stage by stage: a stage takes new
// data only when it is empty or its content moves on, so a stall neither drops nor repeats.
module sprite_quad_vertex_transform
  import sqvt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // in_tdata, from bit 0 up: pos_x, pos_y, angle, zero padding.
  input  wire logic [IN_DATA_W-1:0]  in_tdata,

  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // out_tdata, from bit 0 up: vertex_x, vertex_y.
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // out_tuser, from bit 0 up: vertex_index, clipped.
  output logic [OUT_USER_W-1:0]      out_tuser,
  output logic                       out_tlast,

  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Product of a 12-bit extent and a signed sine, then a sum of two products.
  localparam int PROD_W = DIM_W + 1 + TRIG_W;
  localparam int SUM_W  = PROD_W + 1;
  // Room for the scaling by eight or sixteen and the rounding constant.
  localparam int SH_W   = SUM_W + 5;
  localparam int OFF_W  = SH_W - TRIG_FRAC_BITS;
  localparam int SUMP_W = OFF_W + 1;

  localparam logic signed [SUMP_W-1:0] SAT_HI = SUMP_W'((1 << (POS_W - 1)) - 1);
  localparam logic signed [SUMP_W-1:0] SAT_LO = ~SAT_HI;

  // Configuration registers.
  pivot_mode_t       pivot_mode_r;
  logic [DIM_W-1:0]  sprite_width_r;
  logic [DIM_W-1:0]  sprite_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pivot_mode_r    <= PIVOT_CENTER;
      sprite_width_r  <= '0;
      sprite_height_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIVOT_MODE:    pivot_mode_r    <= pivot_mode_t'(cfg_wdata[1:0]);
        CFG_SPRITE_WIDTH:  sprite_width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_SPRITE_HEIGHT: sprite_height_r <= cfg_wdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Stage handshake.
  logic a_ready, b_ready, c_ready, d_ready;
  logic a_valid_r, b_valid_r, c_valid_r, d_valid_r;
  logic out_fire;
  logic [IDX_W-1:0] d_cnt_r;

  assign out_fire  = out_tvalid && out_tready;
  assign d_ready   = !d_valid_r || (out_tready && (d_cnt_r == LAST_CORNER));
  assign c_ready   = !c_valid_r || d_ready;
  assign b_ready   = !b_valid_r || c_ready;
  assign a_ready   = !a_valid_r || b_ready;
  assign in_tready = a_ready;

  // Input fields and sine table addresses. The cosine is the sine a quarter turn on.
  logic signed [POS_W-1:0]      in_pos_x, in_pos_y;
  logic        [ANGLE_BITS-1:0] in_angle, cos_angle;
  logic        [SINE_ADDR_W-1:0] sin_addr, cos_addr;

  assign in_pos_x  = in_tdata[POS_W-1:0];
  assign in_pos_y  = in_tdata[2*POS_W-1:POS_W];
  assign in_angle  = in_tdata[2*POS_W +: ANGLE_BITS];
  assign cos_angle = in_angle + ANGLE_BITS'(QUARTER);

  // Odd quadrants read the table backwards from the quarter turn.
  assign sin_addr = in_angle[ANGLE_BITS-2]
                  ? SINE_ADDR_W'(QUARTER) - {1'b0, in_angle[ANGLE_BITS-3:0]}
                  : {1'b0, in_angle[ANGLE_BITS-3:0]};
  assign cos_addr = cos_angle[ANGLE_BITS-2]
                  ? SINE_ADDR_W'(QUARTER) - {1'b0, cos_angle[ANGLE_BITS-3:0]}
                  : {1'b0, cos_angle[ANGLE_BITS-3:0]};

  sine_req_t rom_req;
  sine_rsp_t rom_rsp;

  assign rom_req.en       = a_ready && in_tvalid;
  assign rom_req.sin_addr = sin_addr;
  assign rom_req.cos_addr = cos_addr;

  sqvt_sine_rom u_sine_rom (
    .clk (clk),
    .req (rom_req),
    .rsp (rom_rsp)
  );

  // Stage A: table read, with the quadrant signs and the position alongside.
  logic                    a_sin_neg_r, a_cos_neg_r;
  logic signed [POS_W-1:0] a_pos_x_r, a_pos_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_tvalid) begin
      a_sin_neg_r <= in_angle[ANGLE_BITS-1];
      a_cos_neg_r <= cos_angle[ANGLE_BITS-1];
      a_pos_x_r   <= in_pos_x;
      a_pos_y_r   <= in_pos_y;
    end
  end

  // Stage B: the four extent by trig products, in whole-pixel extent units.
  logic signed [TRIG_W-1:0] sin_val, cos_val;
  logic signed [DIM_W:0]    w_ext, h_ext;
  logic signed [PROD_W-1:0] b_wc_r, b_ws_r, b_hc_r, b_hs_r;
  logic signed [POS_W-1:0]  b_pos_x_r, b_pos_y_r;

  assign sin_val = a_sin_neg_r ? -$signed({1'b0, rom_rsp.sin_mag})
                               :  $signed({1'b0, rom_rsp.sin_mag});
  assign cos_val = a_cos_neg_r ? -$signed({1'b0, rom_rsp.cos_mag})
                               :  $signed({1'b0, rom_rsp.cos_mag});
  assign w_ext   = $signed({1'b0, sprite_width_r});
  assign h_ext   = $signed({1'b0, sprite_height_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid_r) begin
      b_wc_r    <= PROD_W'(w_ext) * PROD_W'(cos_val);
      b_ws_r    <= PROD_W'(w_ext) * PROD_W'(sin_val);
      b_hc_r    <= PROD_W'(h_ext) * PROD_W'(cos_val);
      b_hs_r    <= PROD_W'(h_ext) * PROD_W'(sin_val);
      b_pos_x_r <= a_pos_x_r;
      b_pos_y_r <= a_pos_y_r;
    end
  end

  // Stage C: sums, scaling to Q.4 and one rounding with ties toward plus infinity.
  // Rounding down an arithmetic shift of the biased value gives exactly that tie rule.
  function automatic logic signed [OFF_W-1:0] round_off(input logic signed [SUM_W-1:0] v,
                                                       input logic full_edge);
    logic signed [SH_W-1:0] sv;
    sv = full_edge ? (SH_W'(v) <<< 4) : (SH_W'(v) <<< 3);
    sv = sv + (SH_W'(1) << (TRIG_FRAC_BITS - 1));
    return sv[SH_W-1:TRIG_FRAC_BITS];
  endfunction

  logic signed [SUM_W-1:0] sum_a, sum_b, sum_d, sum_e;
  logic signed [SUM_W-1:0] sum_wc, sum_ws, sum_nhs, sum_hc;
  logic signed [OFF_W-1:0] r_a, r_b, r_d, r_e, r_wc, r_ws, r_nhs, r_hc;
  logic signed [OFF_W-1:0] w_full, h_full;
  logic                    full_edge;
  logic signed [OFF_W-1:0] dx [CORNERS];
  logic signed [OFF_W-1:0] dy [CORNERS];
  logic signed [OFF_W-1:0] c_dx_r [CORNERS];
  logic signed [OFF_W-1:0] c_dy_r [CORNERS];
  logic signed [POS_W-1:0] c_pos_x_r, c_pos_y_r;

  assign sum_a   = SUM_W'(b_wc_r) - SUM_W'(b_hs_r);
  assign sum_b   = SUM_W'(b_hc_r) + SUM_W'(b_ws_r);
  assign sum_d   = SUM_W'(b_wc_r) + SUM_W'(b_hs_r);
  assign sum_e   = SUM_W'(b_hc_r) - SUM_W'(b_ws_r);
  assign sum_wc  = SUM_W'(b_wc_r);
  assign sum_ws  = SUM_W'(b_ws_r);
  assign sum_nhs = -SUM_W'(b_hs_r);
  assign sum_hc  = SUM_W'(b_hc_r);

  // Centre mode works on half extents, top-left mode on full edges.
  assign full_edge = (pivot_mode_r == PIVOT_TOP_LEFT);

  assign r_a   = round_off(sum_a,   full_edge);
  assign r_b   = round_off(sum_b,   full_edge);
  assign r_d   = round_off(sum_d,   full_edge);
  assign r_e   = round_off(sum_e,   full_edge);
  assign r_wc  = round_off(sum_wc,  full_edge);
  assign r_ws  = round_off(sum_ws,  full_edge);
  assign r_nhs = round_off(sum_nhs, full_edge);
  assign r_hc  = round_off(sum_hc,  full_edge);

  assign w_full = $signed({{(OFF_W - DIM_W - 4){1'b0}}, sprite_width_r, 4'b0000});
  assign h_full = $signed({{(OFF_W - DIM_W - 4){1'b0}}, sprite_height_r, 4'b0000});

  always_comb begin
    for (int k = 0; k < CORNERS; k++) begin
      dx[k] = '0;
      dy[k] = '0;
    end
    case (pivot_mode_r)
      PIVOT_CENTER: begin
        dx[0] = -r_a;  dy[0] = -r_b;
        dx[1] =  r_d;  dy[1] = -r_e;
        dx[2] = -r_d;  dy[2] =  r_e;
        dx[3] =  r_a;  dy[3] =  r_b;
      end
      PIVOT_TOP_LEFT: begin
        dx[1] = r_wc;  dy[1] = r_ws;
        dx[2] = r_nhs; dy[2] = r_hc;
        dx[3] = r_a;   dy[3] = r_b;
      end
      PIVOT_TOP_RIGHT: begin
        // No rotation: the quad spans leftwards and downwards from the position.
        dx[0] = -w_full;
        dx[2] = -w_full; dy[2] = h_full;
        dy[3] = h_full;
      end
      default: begin
        // The unused mode code puts every corner on the position.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (c_ready) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && b_valid_r) begin
      for (int k = 0; k < CORNERS; k++) begin
        c_dx_r[k] <= dx[k];
        c_dy_r[k] <= dy[k];
      end
      c_pos_x_r <= b_pos_x_r;
      c_pos_y_r <= b_pos_y_r;
    end
  end

  // Stage D: add the position and saturate to 16 bits; this is also the output buffer,
  // which hands out its four corners one transaction at a time.
  logic signed [SUMP_W-1:0] sum_x, sum_y;
  logic signed [POS_W-1:0]  vx [CORNERS];
  logic signed [POS_W-1:0]  vy [CORNERS];
  logic                     vclip [CORNERS];
  logic signed [POS_W-1:0]  d_x_r [CORNERS];
  logic signed [POS_W-1:0]  d_y_r [CORNERS];
  logic                     d_clip_r [CORNERS];

  always_comb begin
    sum_x = '0;
    sum_y = '0;
    for (int k = 0; k < CORNERS; k++) begin
      sum_x    = SUMP_W'(c_pos_x_r) + SUMP_W'(c_dx_r[k]);
      sum_y    = SUMP_W'(c_pos_y_r) + SUMP_W'(c_dy_r[k]);
      vclip[k] = 1'b0;
      if (sum_x > SAT_HI) begin
        vx[k] = SAT_HI[POS_W-1:0];  vclip[k] = 1'b1;
      end else if (sum_x < SAT_LO) begin
        vx[k] = SAT_LO[POS_W-1:0];  vclip[k] = 1'b1;
      end else begin
        vx[k] = sum_x[POS_W-1:0];
      end
      if (sum_y > SAT_HI) begin
        vy[k] = SAT_HI[POS_W-1:0];  vclip[k] = 1'b1;
      end else if (sum_y < SAT_LO) begin
        vy[k] = SAT_LO[POS_W-1:0];  vclip[k] = 1'b1;
      end else begin
        vy[k] = sum_y[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (d_ready) begin
      d_valid_r <= c_valid_r;
    end
  end

  // The counter wraps back to the first corner after the last one is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_cnt_r <= '0;
    end else if (out_fire) begin
      d_cnt_r <= d_cnt_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && c_valid_r) begin
      for (int k = 0; k < CORNERS; k++) begin
        d_x_r[k]    <= vx[k];
        d_y_r[k]    <= vy[k];
        d_clip_r[k] <= vclip[k];
      end
    end
  end

  assign out_tvalid = d_valid_r;
  assign out_tdata  = {d_y_r[d_cnt_r], d_x_r[d_cnt_r]};
  assign out_tuser  = {d_clip_r[d_cnt_r], d_cnt_r};
  assign out_tlast  = (d_cnt_r == LAST_CORNER);

endmodule

`default_nettype wire

@@ sv/sqvt_sine_rom.sv @@
`default_nettype none

// Quarter-wave sine ROM with two registered read ports.
module sqvt_sine_rom
  import sqvt_pkg::*;
(
  input  wire logic      clk,
  input  wire sine_req_t req,
  output sine_rsp_t      rsp
);

  localparam sine_tab_t SINE_TAB = sqvt_build_sine();

  sine_rsp_t rsp_r;

  always_ff @(posedge clk) begin
    if (req.en) begin
      rsp_r.sin_mag <= SINE_TAB[req.sin_addr];
      rsp_r.cos_mag <= SINE_TAB[req.cos_addr];
    end
  end

  assign rsp = rsp_r;

endmodule

`default_nettype wire
